### rtl/websocket_frame_parser_macros.svh
// assertion macros for the websocket frame parser checker
// expects clk and rst_n in the scope where a macro is used
`ifndef WEBSOCKET_FRAME_PARSER_MACROS_SVH
`define WEBSOCKET_FRAME_PARSER_MACROS_SVH

// same-cycle implication, off while in reset
`define WSFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfp check failed: same-cycle rule");

// next-cycle implication, off while in reset
`define WSFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfp check failed: next-cycle rule");

// next-cycle implication that also holds through reset
`define WSFP_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wsfp check failed: reset rule");

`endif

### rtl/wsfp_pkg.sv
// types and constants of the websocket frame parser
// no dependencies; used by every other file of the block but the assertion macros header
`timescale 1ns / 1ps

package wsfp_pkg;

  // decoder phase
  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_LEN16   = 3'd2,
    PH_LEN64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  // result event codes
  localparam logic [1:0] EV_HDR_DONE = 2'd0;
  localparam logic [1:0] EV_DATA     = 2'd1;
  localparam logic [1:0] EV_ERROR    = 2'd2;

  // error codes
  localparam logic [1:0] ERR_SHORT   = 2'd0;
  localparam logic [1:0] ERR_EXT_LEN = 2'd1;
  localparam logic [1:0] ERR_MASK    = 2'd2;
  localparam logic [1:0] ERR_PAYLOAD = 2'd3;

  // 7-bit length escapes and extended length end points
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] HDR_END16  = 4'd4;
  localparam logic [3:0] HDR_END64  = 4'd10;

  localparam int PAYLOAD_LEN_W = 64;

  // one result item plus its valid flag
  typedef struct packed {
    logic                     valid;
    logic [1:0]               event_res;
    logic                     fin;
    logic [2:0]               rsv;
    logic [3:0]               opcode;
    logic                     masked;
    logic [PAYLOAD_LEN_W-1:0] payload_length;
    logic [7:0]               data_byte;
    logic [1:0]               error_code;
    logic [3:0]               header_length;
    logic                     frame_end;
  } res_t;

endpackage

### rtl/wsfp_stream_if.sv
// valid/ready channel interfaces of the websocket frame parser
// depends on wsfp_pkg for the payload length width
`timescale 1ns / 1ps

interface wsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface wsfp_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        event_res;
  logic                              fin;
  logic [2:0]                        rsv;
  logic [3:0]                        opcode;
  logic                              masked;
  logic [wsfp_pkg::PAYLOAD_LEN_W-1:0] payload_length;
  logic [7:0]                        data_byte;
  logic [1:0]                        error_code;
  logic [3:0]                        header_length;
  logic                              frame_end;

  modport source (output valid, output event_res, output fin, output rsv, output opcode,
                  output masked, output payload_length, output data_byte,
                  output error_code, output header_length, output frame_end,
                  input ready);
  modport sink (input valid, input event_res, input fin, input rsv, input opcode,
                input masked, input payload_length, input data_byte,
                input error_code, input header_length, input frame_end,
                output ready);
endinterface

### rtl/websocket_frame_parser.sv
// websocket frame parser: input byte register, frame decoder, result register
// depends on wsfp_pkg, wsfp_stream_if (wsfp_in_if, wsfp_out_if) and wsfp_frame_fsm
`timescale 1ns / 1ps

// Usage
//   in_ch carries one received byte per item with buffer_end marking the last
//   byte of a data buffer. out_ch carries at most one result item per input
//   item: header done for an empty payload, one unmasked payload byte, or an
//   error code when the buffer ends before the frame is complete.
//   Items with no result (header, length and key bytes) are absorbed silently.
//   An accepted item lands in the input register, is decoded from there when
//   the result register is free or being emptied, and its result is registered.
//   Throughput: one byte per cycle while out_ch is not stalled; the frame state
//   is updated in the same cycle that the result register is written, so
//   consecutive bytes follow without gaps.
//   When out_ch is stalled the result register holds; one more item waits in
//   the input register, then in_ch.ready drops until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers and puts the decoder
//   back at the first header byte.
//   LENGTH_BITS (16..64) sets the width of the kept payload length; higher
//   length bits are dropped.

module websocket_frame_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  wsfp_in_if.sink          in_ch,
  wsfp_out_if.source       out_ch
);

  logic           s1_valid_r, s1_valid_nxt;
  logic [7:0]     in_byte_r;
  logic           in_end_r;
  logic           out_valid_r, out_valid_nxt;
  wsfp_pkg::res_t res;
  wsfp_pkg::res_t res_r;
  logic           advance;
  logic           step;
  logic           in_take;

  // decode goes ahead whenever the result register is free or being emptied
  assign advance      = !out_valid_r || out_ch.ready;
  assign step         = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_take ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step ? res.valid : (out_ch.ready ? 1'b0 : out_valid_r);

  wsfp_frame_fsm #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (in_byte_r),
    .buffer_end (in_end_r),
    .res        (res)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.rx_byte;
      in_end_r  <= in_ch.buffer_end;
    end
  end

  // result item register
  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_res      = res_r.event_res;
  assign out_ch.fin            = res_r.fin;
  assign out_ch.rsv            = res_r.rsv;
  assign out_ch.opcode         = res_r.opcode;
  assign out_ch.masked         = res_r.masked;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.data_byte      = res_r.data_byte;
  assign out_ch.error_code     = res_r.error_code;
  assign out_ch.header_length  = res_r.header_length;
  assign out_ch.frame_end      = res_r.frame_end;

endmodule

### rtl/wsfp_frame_fsm.sv
// frame header decoder state and payload unmasking for one byte per step
// depends on wsfp_pkg (phase type, codes, result struct)
`timescale 1ns / 1ps

module wsfp_frame_fsm #(
  parameter int LENGTH_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             buffer_end,
  output wsfp_pkg::res_t   res
);

  // frame state
  wsfp_pkg::phase_t        phase_r, phase_nxt;
  logic [3:0]              hc_r, hc_nxt;
  logic [7:0]              fhb_r, fhb_nxt;
  logic                    mask_r, mask_nxt;
  logic [LENGTH_BITS-1:0]  acc_r, acc_nxt;
  logic [31:0]             key_r, key_nxt;
  logic [LENGTH_BITS-1:0]  rem_r, rem_nxt;
  logic [1:0]              mp_r, mp_nxt;
  logic                    ld_r, ld_nxt;

  // values after this byte, before a frame restart
  wsfp_pkg::phase_t        u_phase;
  logic [3:0]              u_hc;
  logic [7:0]              u_fhb;
  logic                    u_mask;
  logic [LENGTH_BITS-1:0]  u_acc;
  logic [31:0]             u_key;
  logic [LENGTH_BITS-1:0]  u_rem;
  logic [1:0]              u_mp;
  logic                    u_ld;

  // decision for this byte
  logic                    emit;
  logic [1:0]              ev;
  logic [1:0]              code;
  logic                    fend;
  logic [7:0]              data;
  logic                    restart;

  logic [6:0]              len7;
  logic [7:0]              key_byte;
  logic                    go_len;
  logic                    go_key;

  assign len7 = rx_byte[6:0];

  // key byte for the current payload position, first key byte in the top bits
  always_comb begin
    case (mp_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state: per-phase update, then length and key completion
  always_comb begin
    u_phase = phase_r;
    u_hc    = hc_r;
    u_fhb   = fhb_r;
    u_mask  = mask_r;
    u_acc   = acc_r;
    u_key   = key_r;
    u_rem   = rem_r;
    u_mp    = mp_r;
    u_ld    = ld_r;
    emit    = 1'b0;
    ev      = wsfp_pkg::EV_DATA;
    code    = wsfp_pkg::ERR_SHORT;
    fend    = 1'b0;
    data    = 8'd0;
    restart = 1'b0;
    go_len  = 1'b0;
    go_key  = 1'b0;

    unique case (phase_r)
      wsfp_pkg::PH_SECOND: begin
        u_mask = rx_byte[7];
        u_key  = '0;
        u_hc   = 4'd2;
        if (len7 == wsfp_pkg::LEN7_EXT16 || len7 == wsfp_pkg::LEN7_EXT64) begin
          u_phase = (len7 == wsfp_pkg::LEN7_EXT16) ? wsfp_pkg::PH_LEN16 : wsfp_pkg::PH_LEN64;
          u_acc   = '0;
          if (buffer_end) begin
            emit    = 1'b1;
            ev      = wsfp_pkg::EV_ERROR;
            code    = wsfp_pkg::ERR_EXT_LEN;
            fend    = 1'b1;
            restart = 1'b1;
          end
        end else begin
          u_acc  = LENGTH_BITS'(len7);
          go_len = 1'b1;
        end
      end
      wsfp_pkg::PH_LEN16, wsfp_pkg::PH_LEN64: begin
        u_acc = {acc_r[LENGTH_BITS-9:0], rx_byte};
        u_hc  = hc_r + 4'd1;
        if (u_hc >= ((phase_r == wsfp_pkg::PH_LEN16) ? wsfp_pkg::HDR_END16
                                                     : wsfp_pkg::HDR_END64)) begin
          go_len = 1'b1;
        end else if (buffer_end) begin
          emit    = 1'b1;
          ev      = wsfp_pkg::EV_ERROR;
          code    = wsfp_pkg::ERR_EXT_LEN;
          fend    = 1'b1;
          restart = 1'b1;
        end
      end
      wsfp_pkg::PH_KEY: begin
        u_key = {key_r[23:0], rx_byte};
        u_hc  = hc_r + 4'd1;
        if (mp_r == 2'd3) begin
          u_mp   = 2'd0;
          go_key = 1'b1;
        end else begin
          u_mp = mp_r + 2'd1;
          if (buffer_end) begin
            emit    = 1'b1;
            ev      = wsfp_pkg::EV_ERROR;
            code    = wsfp_pkg::ERR_MASK;
            fend    = 1'b1;
            restart = 1'b1;
          end
        end
      end
      wsfp_pkg::PH_PAYLOAD: begin
        u_rem = rem_r - 1'b1;
        u_mp  = mp_r + 2'd1;
        emit  = 1'b1;
        if (u_rem == '0) begin
          data    = rx_byte ^ key_byte;
          fend    = 1'b1;
          restart = 1'b1;
        end else if (buffer_end) begin
          ev      = wsfp_pkg::EV_ERROR;
          code    = wsfp_pkg::ERR_PAYLOAD;
          fend    = 1'b1;
          restart = 1'b1;
        end else begin
          data = rx_byte ^ key_byte;
        end
      end
      default: begin
        // first header byte, also taken for unused phase codes
        u_fhb  = rx_byte;
        u_hc   = 4'd1;
        u_mask = 1'b0;
        u_acc  = '0;
        u_key  = '0;
        u_rem  = '0;
        u_mp   = 2'd0;
        u_ld   = 1'b0;
        if (buffer_end) begin
          emit    = 1'b1;
          ev      = wsfp_pkg::EV_ERROR;
          code    = wsfp_pkg::ERR_SHORT;
          fend    = 1'b1;
          restart = 1'b1;
        end else begin
          u_phase = wsfp_pkg::PH_SECOND;
        end
      end
    endcase

    // length complete: go to key when masked, else on to header completion
    if (go_len) begin
      u_ld = 1'b1;
      if (u_mask) begin
        u_phase = wsfp_pkg::PH_KEY;
        if (buffer_end) begin
          emit    = 1'b1;
          ev      = wsfp_pkg::EV_ERROR;
          code    = wsfp_pkg::ERR_MASK;
          fend    = 1'b1;
          restart = 1'b1;
        end
      end else begin
        go_key = 1'b1;
      end
    end

    // header complete: empty payload ends the frame here
    if (go_key) begin
      if (u_acc == '0) begin
        emit    = 1'b1;
        ev      = wsfp_pkg::EV_HDR_DONE;
        fend    = 1'b1;
        restart = 1'b1;
      end else begin
        u_phase = wsfp_pkg::PH_PAYLOAD;
        u_rem   = u_acc;
        u_mp    = 2'd0;
        if (buffer_end) begin
          emit    = 1'b1;
          ev      = wsfp_pkg::EV_ERROR;
          code    = wsfp_pkg::ERR_PAYLOAD;
          fend    = 1'b1;
          restart = 1'b1;
        end
      end
    end

    // frame restart keeps only the first header byte
    phase_nxt = restart ? wsfp_pkg::PH_FIRST : u_phase;
    hc_nxt    = restart ? 4'd0 : u_hc;
    fhb_nxt   = u_fhb;
    mask_nxt  = restart ? 1'b0 : u_mask;
    acc_nxt   = restart ? '0 : u_acc;
    key_nxt   = restart ? '0 : u_key;
    rem_nxt   = restart ? '0 : u_rem;
    mp_nxt    = restart ? 2'd0 : u_mp;
    ld_nxt    = restart ? 1'b0 : u_ld;
  end

  // result item built from the updated frame state
  always_comb begin
    res.valid          = step & emit;
    res.event_res      = ev;
    res.fin            = u_fhb[7];
    res.rsv            = u_fhb[6:4];
    res.opcode         = u_fhb[3:0];
    res.masked         = u_mask;
    res.payload_length = u_ld ? wsfp_pkg::PAYLOAD_LEN_W'(u_acc) : '0;
    res.data_byte      = data;
    res.error_code     = code;
    res.header_length  = u_hc;
    res.frame_end      = fend;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsfp_pkg::PH_FIRST;
      hc_r    <= 4'd0;
      mp_r    <= 2'd0;
      ld_r    <= 1'b0;
      mask_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      mp_r    <= mp_nxt;
      ld_r    <= ld_nxt;
      mask_r  <= mask_nxt;
    end
  end

  // header and length data
  always_ff @(posedge clk) begin
    if (step) begin
      fhb_r <= fhb_nxt;
      acc_r <= acc_nxt;
      key_r <= key_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

### rtl/wsfp_checker.sv
// port-level checks of the websocket frame parser, bound to the top level
// depends on wsfp_pkg and websocket_frame_parser_macros.svh
`timescale 1ns / 1ps
`include "websocket_frame_parser_macros.svh"

module wsfp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         event_res,
  input logic [wsfp_pkg::PAYLOAD_LEN_W-1:0] payload_length,
  input logic [3:0]                         header_length,
  input logic                               frame_end
);

  // a stalled result item stays offered
  `WSFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // an error always closes the frame
  `WSFP_ASSERT_NOW(a_err_ends, out_valid && event_res == wsfp_pkg::EV_ERROR, frame_end)

  // header done only for an empty payload and always ends the frame
  `WSFP_ASSERT_NOW(a_hdr_done, out_valid && event_res == wsfp_pkg::EV_HDR_DONE, frame_end && payload_length == '0)

  // payload bytes only come after a complete header
  `WSFP_ASSERT_NOW(a_data_hdr, out_valid && event_res == wsfp_pkg::EV_DATA, header_length >= 4'd2 && payload_length != '0)

  // reset empties the result register
  `WSFP_ASSERT_ALWAYS_NEXT(a_rst_empty, !rst_n, !out_valid)

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .event_res      (out_ch.event_res),
  .payload_length (out_ch.payload_length),
  .header_length  (out_ch.header_length),
  .frame_end      (out_ch.frame_end)
);

### test/tb_websocket_frame_parser.sv
// self-checking testbench for the websocket frame parser
// drives bytes over wsfp_in_if, checks results on wsfp_out_if against a frame decoder model
// depends on wsfp_pkg, wsfp_stream_if and websocket_frame_parser
`timescale 1ns / 1ps

module tb_websocket_frame_parser;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 650;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int MAX_SENT_PAY = 48;

  // error_code value carried by results that are not errors
  localparam logic [1:0] NO_ERR = 2'd0;

  typedef struct packed {
    logic [7:0] rx;
    logic       last;
    logic       pinned;
    logic [1:0] ev;
    logic [1:0] code;
    logic [3:0] hlen;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } wire_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  wsfp_in_if  in_ch ();
  wsfp_out_if out_ch ();

  websocket_frame_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // directed stimulus; pinned rows carry a result readable straight from the protocol
  stim_row_t dir_rows [0:25] = '{
    // lone first byte that ends the buffer: too short
    '{8'hFF, 1'b1, 1'b1, wsfp_pkg::EV_ERROR,    wsfp_pkg::ERR_SHORT,   4'd1},
    // minimal frame with empty payload, buffer ends exactly at frame end
    '{8'h81, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h00, 1'b1, 1'b1, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd2},
    // 16-bit length escape cut off by buffer end
    '{8'h02, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h7E, 1'b1, 1'b1, wsfp_pkg::EV_ERROR,    wsfp_pkg::ERR_EXT_LEN, 4'd2},
    // masked frame, 16-bit length 3, buffer ends after two payload bytes
    '{8'h82, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFE, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h00, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h03, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h00, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hAA, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h55, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h12, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h34, 1'b1, 1'b1, wsfp_pkg::EV_ERROR,    wsfp_pkg::ERR_PAYLOAD, 4'd8},
    // 64-bit length of all ones, key cut off after its first byte
    '{8'h0A, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'hFF, 1'b0, 1'b0, wsfp_pkg::EV_HDR_DONE, NO_ERR,                4'd0},
    '{8'h01, 1'b1, 1'b1, wsfp_pkg::EV_ERROR,    wsfp_pkg::ERR_MASK,    4'd11}
  };

  // decoder model state
  wsfp_pkg::phase_t ph;
  logic [3:0]  hcnt;
  logic [7:0]  hdr0;
  logic        mbit;
  logic [63:0] len_acc;
  logic [31:0] key;
  logic [63:0] remain;
  logic [1:0]  kpos;
  logic        len_known;

  wsfp_pkg::res_t pending_events [$];
  int   fail_count  = 0;
  int   items_sent  = 0;
  int   burst_left  = 0;
  int   results_in  = 0;
  int   ev_count  [4] = '{0, 0, 0, 0};
  int   err_count [4] = '{0, 0, 0, 0};
  logic [7:0] stall_tick = 8'd0;

  function automatic void frame_restart();
    ph        = wsfp_pkg::PH_FIRST;
    hcnt      = 4'd0;
    mbit      = 1'b0;
    len_acc   = '0;
    key       = '0;
    remain    = '0;
    kpos      = 2'd0;
    len_known = 1'b0;
  endfunction

  function automatic wsfp_pkg::res_t make_res(input logic [1:0] ev, input logic [1:0] code,
                                              input logic fend, input logic [7:0] d);
    wsfp_pkg::res_t r;
    r.valid          = 1'b1;
    r.event_res      = ev;
    r.fin            = hdr0[7];
    r.rsv            = hdr0[6:4];
    r.opcode         = hdr0[3:0];
    r.masked         = mbit;
    r.payload_length = len_known ? len_acc : '0;
    r.data_byte      = d;
    r.error_code     = code;
    r.header_length  = hcnt;
    r.frame_end      = fend;
    return r;
  endfunction

  function automatic wsfp_pkg::res_t fail_frame(input logic [1:0] code);
    wsfp_pkg::res_t r;
    r = make_res(wsfp_pkg::EV_ERROR, code, 1'b1, 8'h00);
    frame_restart();
    return r;
  endfunction

  // header complete: empty payload ends the frame, else payload follows
  function automatic bit key_done(input logic last, output wsfp_pkg::res_t r);
    r = '0;
    if (len_acc == '0) begin
      r = make_res(wsfp_pkg::EV_HDR_DONE, NO_ERR, 1'b1, 8'h00);
      frame_restart();
      return 1'b1;
    end
    ph     = wsfp_pkg::PH_PAYLOAD;
    remain = len_acc;
    kpos   = 2'd0;
    if (last) begin
      r = fail_frame(wsfp_pkg::ERR_PAYLOAD);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit length_done(input logic last, output wsfp_pkg::res_t r);
    r = '0;
    len_known = 1'b1;
    if (mbit) begin
      ph = wsfp_pkg::PH_KEY;
      if (last) begin
        r = fail_frame(wsfp_pkg::ERR_MASK);
        return 1'b1;
      end
      return 1'b0;
    end
    return key_done(last, r);
  endfunction

  // one received byte through the frame decoder; returns 1 when it makes a result
  function automatic bit ws_decode(input logic [7:0] b, input logic last,
                                   output wsfp_pkg::res_t r);
    logic [6:0] l7;
    logic [3:0] hend;
    logic [7:0] kb;
    r = '0;
    case (ph)
      wsfp_pkg::PH_SECOND: begin
        l7   = b[6:0];
        mbit = b[7];
        key  = '0;
        hcnt = 4'd2;
        if (l7 == wsfp_pkg::LEN7_EXT16 || l7 == wsfp_pkg::LEN7_EXT64) begin
          ph      = (l7 == wsfp_pkg::LEN7_EXT16) ? wsfp_pkg::PH_LEN16 : wsfp_pkg::PH_LEN64;
          len_acc = '0;
          if (last) begin
            r = fail_frame(wsfp_pkg::ERR_EXT_LEN);
            return 1'b1;
          end
          return 1'b0;
        end
        len_acc = {57'd0, l7};
        return length_done(last, r);
      end
      wsfp_pkg::PH_LEN16, wsfp_pkg::PH_LEN64: begin
        hend    = (ph == wsfp_pkg::PH_LEN16) ? wsfp_pkg::HDR_END16 : wsfp_pkg::HDR_END64;
        len_acc = {len_acc[55:0], b};
        hcnt    = hcnt + 4'd1;
        if (hcnt >= hend) return length_done(last, r);
        if (last) begin
          r = fail_frame(wsfp_pkg::ERR_EXT_LEN);
          return 1'b1;
        end
        return 1'b0;
      end
      wsfp_pkg::PH_KEY: begin
        key  = {key[23:0], b};
        hcnt = hcnt + 4'd1;
        if (kpos == 2'd3) begin
          kpos = 2'd0;
          return key_done(last, r);
        end
        kpos = kpos + 2'd1;
        if (last) begin
          r = fail_frame(wsfp_pkg::ERR_MASK);
          return 1'b1;
        end
        return 1'b0;
      end
      wsfp_pkg::PH_PAYLOAD: begin
        kb     = key[8 * (3 - kpos) +: 8];
        remain = remain - 64'd1;
        kpos   = kpos + 2'd1;
        if (remain == '0) begin
          r = make_res(wsfp_pkg::EV_DATA, NO_ERR, 1'b1, b ^ kb);
          frame_restart();
          return 1'b1;
        end
        // buffer end inside payload drops the byte in favor of the error
        if (last) begin
          r = fail_frame(wsfp_pkg::ERR_PAYLOAD);
          return 1'b1;
        end
        r = make_res(wsfp_pkg::EV_DATA, NO_ERR, 1'b0, b ^ kb);
        return 1'b1;
      end
      default: begin
        frame_restart();
        hdr0 = b;
        hcnt = 4'd1;
        if (last) begin
          r = fail_frame(wsfp_pkg::ERR_SHORT);
          return 1'b1;
        end
        ph = wsfp_pkg::PH_SECOND;
        return 1'b0;
      end
    endcase
  endfunction

  // sender: bursts of items with random gaps, driven at the falling edge
  task automatic push_byte(input logic [7:0] b, input logic last,
                           output bit produced, output wsfp_pkg::res_t r);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_ch.valid      <= 1'b1;
    in_ch.rx_byte    <= b;
    in_ch.buffer_end <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    produced = ws_decode(b, last, r);
    if (produced) pending_events.insert(pending_events.size(), r);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // one frame with random content; mostly well formed, sometimes cut by buffer end
  task automatic send_random_frame();
    wire_byte_t     fr [$];
    logic           mk;
    logic [63:0]    plen;
    int             pick;
    int             n_pay;
    int             cut;
    bit             produced;
    wsfp_pkg::res_t r;
    mk   = $urandom_range(0, 1);
    pick = $urandom_range(0, 9);
    fr.insert(fr.size(), wire_byte_t'{8'($urandom), 1'b0});
    if (pick < 6) begin
      plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      fr.insert(fr.size(), wire_byte_t'{{mk, plen[6:0]}, 1'b0});
    end else if (pick < 8) begin
      plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      fr.insert(fr.size(), wire_byte_t'{{mk, wsfp_pkg::LEN7_EXT16}, 1'b0});
      fr.insert(fr.size(), wire_byte_t'{plen[15:8], 1'b0});
      fr.insert(fr.size(), wire_byte_t'{plen[7:0], 1'b0});
    end else begin
      if ($urandom_range(0, 2) == 0) plen = {$urandom, $urandom};
      else plen = $urandom_range(0, 40);
      fr.insert(fr.size(), wire_byte_t'{{mk, wsfp_pkg::LEN7_EXT64}, 1'b0});
      for (int i = 7; i >= 0; i--) fr.insert(fr.size(), wire_byte_t'{plen[8 * i +: 8], 1'b0});
    end
    if (mk) repeat (4) fr.insert(fr.size(), wire_byte_t'{8'($urandom), 1'b0});
    n_pay = (plen > MAX_SENT_PAY) ? MAX_SENT_PAY : int'(plen);
    repeat (n_pay) fr.insert(fr.size(), wire_byte_t'{8'($urandom), 1'b0});
    // long payloads are always cut short so the next header is not swallowed
    if (plen > MAX_SENT_PAY || $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, fr.size() - 1);
      fr[cut].last = 1'b1;
      fr = fr[0:cut];
    end else if ($urandom_range(0, 1) == 1) begin
      fr[fr.size() - 1].last = 1'b1;
    end
    foreach (fr[i]) push_byte(fr[i].b, fr[i].last, produced, r);
  endtask

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", fname, want, got);
      fail_count++;
    end
  endfunction

  // receiver: ready pattern cycles through free, random, periodic and long stalls
  always @(negedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    case (stall_tick[7:6])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ch.ready <= (stall_tick[2:0] != 3'd0);
      default: out_ch.ready <= (stall_tick[5:4] == 2'b00) ? 1'b0 : 1'($urandom_range(0, 1));
    endcase
  end

  // result checker: each accepted item against the oldest expectation
  always @(posedge clk) begin : result_check
    wsfp_pkg::res_t got;
    wsfp_pkg::res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.valid          = 1'b1;
      got.event_res      = out_ch.event_res;
      got.fin            = out_ch.fin;
      got.rsv            = out_ch.rsv;
      got.opcode         = out_ch.opcode;
      got.masked         = out_ch.masked;
      got.payload_length = out_ch.payload_length;
      got.data_byte      = out_ch.data_byte;
      got.error_code     = out_ch.error_code;
      got.header_length  = out_ch.header_length;
      got.frame_end      = out_ch.frame_end;
      results_in++;
      ev_count[got.event_res]++;
      if (got.event_res == wsfp_pkg::EV_ERROR) err_count[got.error_code]++;
      if (pending_events.size() == 0) begin
        $error("result item with nothing expected: event %0d", got.event_res);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", want.event_res, got.event_res);
        check_field("fin", want.fin, got.fin);
        check_field("rsv", want.rsv, got.rsv);
        check_field("opcode", want.opcode, got.opcode);
        check_field("masked", want.masked, got.masked);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("error_code", want.error_code, got.error_code);
        check_field("header_length", want.header_length, got.header_length);
        check_field("frame_end", want.frame_end, got.frame_end);
      end
    end
  end

  // main sequence
  initial begin : stimulus
    bit             produced;
    wsfp_pkg::res_t r;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.rx_byte    = 8'h00;
    in_ch.buffer_end = 1'b0;
    out_ch.ready     = 1'b0;
    hdr0             = 8'h00;
    frame_restart();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      push_byte(dir_rows[i].rx, dir_rows[i].last, produced, r);
      if (dir_rows[i].pinned && (!produced || r.event_res != dir_rows[i].ev ||
          r.error_code != dir_rows[i].code || r.header_length != dir_rows[i].hlen)) begin
        $error("directed row %0d: expected event %0d code %0d header %0d", i,
               dir_rows[i].ev, dir_rows[i].code, dir_rows[i].hlen);
        fail_count++;
      end
    end

    // random frames with some loose noise bytes in between
    while (items_sent < RANDOM_ITEMS + $size(dir_rows)) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom), ($urandom_range(0, 3) == 0), produced, r);
      end else begin
        send_random_frame();
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then watch for anything stray
    wait (pending_events.size() == 0);
    repeat (6) @(posedge clk);

    $display("covered %0d input bytes, %0d results: %0d header-done, %0d payload, %0d errors",
             items_sent, results_in, ev_count[wsfp_pkg::EV_HDR_DONE],
             ev_count[wsfp_pkg::EV_DATA], ev_count[wsfp_pkg::EV_ERROR]);
    $display("errors by code: short %0d, ext length %0d, mask key %0d, payload %0d",
             err_count[wsfp_pkg::ERR_SHORT], err_count[wsfp_pkg::ERR_EXT_LEN],
             err_count[wsfp_pkg::ERR_MASK], err_count[wsfp_pkg::ERR_PAYLOAD]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $error("timeout with %0d results still expected", pending_events.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/wsfp_pkg.sv
rtl/wsfp_stream_if.sv
rtl/wsfp_frame_fsm.sv
rtl/websocket_frame_parser.sv
rtl/wsfp_checker.sv
test/tb_websocket_frame_parser.sv
